// ===== hw/rtl/mor_pkg.sv =====
// Package for the matrix orientation reader: sizes, orientation codes and
// the result tag struct. Depends on nothing; every other file imports it.

package mor_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 32;
    localparam int DATA_WIDTH = 32;

    localparam int MAX_DIM    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CFG_W      = 6;
    localparam int ORI_W      = 3;

    // Orientation codes
    localparam logic [ORI_W-1:0] ORI_ORIGINAL = 3'd0;
    localparam logic [ORI_W-1:0] ORI_TRANSPOSE = 3'd1;
    localparam logic [ORI_W-1:0] ORI_ANTI_TRANSPOSE = 3'd2;
    localparam logic [ORI_W-1:0] ORI_ROT180 = 3'd3;
    localparam logic [ORI_W-1:0] ORI_CW = 3'd4;
    localparam logic [ORI_W-1:0] ORI_CCW = 3'd5;

    // Input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // Register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Tag that travels with each read beat
    typedef struct packed {
        logic [ORI_W-1:0] orientation;
        logic             row_end;
        logic             orientation_end;
        logic             last;
    } meta_t;

endpackage

// ===== hw/rtl/mor_seq.sv =====
// Load and read sequencer: steps the load and orientation counters and forms
// the store address and the result tag. Depends on mor_pkg.

module mor_seq
    import mor_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              op,
    input  logic              restart,
    input  logic [CFG_W-1:0]  rows,
    input  logic [CFG_W-1:0]  cols,
    output logic              mem_we,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_addr,
    output meta_t             meta
);

    localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);

    logic             emitting_reg, emitting_next;
    logic [IDX_W-1:0] load_row_reg, load_row_next;
    logic [IDX_W-1:0] load_col_reg, load_col_next;
    logic [ORI_W-1:0] orient_reg, orient_next;
    logic [IDX_W-1:0] outer_reg, outer_next;
    logic [IDX_W-1:0] inner_reg, inner_next;

    logic [CFG_W-1:0] h_clamp, w_clamp;
    logic [IDX_W-1:0] h_m1, w_m1, outer_m1, inner_m1;
    logic [IDX_W-1:0] rd_row, rd_col;
    logic             load_row_end, load_last;
    logic             rend, oend, lst;

    // Zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (rows == '0)
            h_clamp = CFG_W'(1);
        else if (rows > MAX_ROWS_C)
            h_clamp = MAX_ROWS_C;
        else
            h_clamp = rows;
        if (cols == '0)
            w_clamp = CFG_W'(1);
        else if (cols > MAX_COLS_C)
            w_clamp = MAX_COLS_C;
        else
            w_clamp = cols;
    end

    assign h_m1 = IDX_W'(h_clamp - CFG_W'(1));
    assign w_m1 = IDX_W'(w_clamp - CFG_W'(1));

    assign outer_m1 = (orient_reg == ORI_ORIGINAL || orient_reg == ORI_ROT180) ? h_m1 : w_m1;
    assign inner_m1 = (orient_reg == ORI_ORIGINAL || orient_reg == ORI_ROT180) ? w_m1 : h_m1;

    always_comb
    begin
        unique case (orient_reg)
            ORI_ORIGINAL:
            begin
                rd_row = outer_reg;
                rd_col = inner_reg;
            end
            ORI_TRANSPOSE:
            begin
                rd_row = inner_reg;
                rd_col = outer_reg;
            end
            ORI_ANTI_TRANSPOSE:
            begin
                rd_row = h_m1 - inner_reg;
                rd_col = w_m1 - outer_reg;
            end
            ORI_ROT180:
            begin
                rd_row = h_m1 - outer_reg;
                rd_col = w_m1 - inner_reg;
            end
            ORI_CW:
            begin
                rd_row = h_m1 - inner_reg;
                rd_col = outer_reg;
            end
            default:
            begin
                rd_row = inner_reg;
                rd_col = w_m1 - outer_reg;
            end
        endcase
    end

    assign rend = (inner_reg == inner_m1);
    assign oend = rend && (outer_reg == outer_m1);
    assign lst  = oend && (orient_reg >= ORI_CCW);

    assign load_row_end = (load_col_reg == w_m1);
    assign load_last    = load_row_end && (load_row_reg == h_m1);

    assign mem_we = fire && (op == OP_LOAD) && !emitting_reg;
    assign mem_re = fire && (op == OP_PULL) && emitting_reg;

    always_comb
    begin
        if (emitting_reg)
            mem_addr = ADDR_W'(rd_row * MAX_COLS + rd_col);
        else
            mem_addr = ADDR_W'(load_row_reg * MAX_COLS + load_col_reg);
    end

    assign meta.orientation     = orient_reg;
    assign meta.row_end         = rend;
    assign meta.orientation_end = oend;
    assign meta.last            = lst;

    always_comb
    begin
        emitting_next = emitting_reg;
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        orient_next   = orient_reg;
        outer_next    = outer_reg;
        inner_next    = inner_reg;
        priority if (restart)
        begin
            emitting_next = 1'b0;
            load_row_next = '0;
            load_col_next = '0;
            orient_next   = ORI_ORIGINAL;
            outer_next    = '0;
            inner_next    = '0;
        end
        else if (mem_we)
        begin
            if (load_last)
            begin
                emitting_next = 1'b1;
                load_row_next = '0;
                load_col_next = '0;
                orient_next   = ORI_ORIGINAL;
                outer_next    = '0;
                inner_next    = '0;
            end
            else if (load_row_end)
            begin
                load_row_next = load_row_reg + IDX_W'(1);
                load_col_next = '0;
            end
            else
                load_col_next = load_col_reg + IDX_W'(1);
        end
        else if (mem_re)
        begin
            if (lst)
            begin
                emitting_next = 1'b0;
                orient_next   = ORI_ORIGINAL;
                outer_next    = '0;
                inner_next    = '0;
            end
            else if (oend)
            begin
                orient_next = orient_reg + ORI_W'(1);
                outer_next  = '0;
                inner_next  = '0;
            end
            else if (rend)
            begin
                outer_next = outer_reg + IDX_W'(1);
                inner_next = '0;
            end
            else
                inner_next = inner_reg + IDX_W'(1);
        end
        else
        begin
            emitting_next = emitting_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitting_reg <= 1'b0;
            load_row_reg <= '0;
            load_col_reg <= '0;
            orient_reg   <= ORI_ORIGINAL;
            outer_reg    <= '0;
            inner_reg    <= '0;
        end
        else
        begin
            emitting_reg <= emitting_next;
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            orient_reg   <= orient_next;
            outer_reg    <= outer_next;
            inner_reg    <= inner_next;
        end
    end

endmodule

// ===== hw/rtl/mor_mem.sv =====
// Matrix store: one word per element, one shared address, registered read.
// Depends on mor_pkg.

module mor_mem
    import mor_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic                  re,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [DATA_WIDTH-1:0] wdata,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mor_out.sv =====
// Result path: tag stage aligned with the store read, then the output beat
// register. Depends on mor_pkg.

module mor_out
    import mor_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  meta_t                 meta_in,
    input  logic [DATA_WIDTH-1:0] rdata,
    output logic                  stall,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_data,
    output meta_t                 out_meta
);

    logic                  s1_valid_reg, s1_valid_next;
    meta_t                 s1_meta_reg;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    meta_t                 out_meta_reg;
    logic                  out_free;

    assign out_free = !out_valid_reg || out_ready;
    // Hold the read stage while the output beat is stuck
    assign stall    = s1_valid_reg && !out_free;

    always_comb
    begin
        if (load)
            s1_valid_next = 1'b1;
        else if (out_free)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s1_meta_reg <= meta_in;
        if (out_free && s1_valid_reg)
        begin
            out_data_reg <= rdata;
            out_meta_reg <= s1_meta_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_meta  = out_meta_reg;

endmodule

// ===== hw/rtl/matrix_orientation_reader.sv =====
// Matrix orientation reader, top level: stream ports, register port and the
// sequencer, store and result path. Depends on mor_pkg, mor_seq, mor_mem, mor_out.
//
// Usage: set rows and cols over the register port (offsets 0 and 4) while idle;
// each write restarts the block in the loading phase. Then send rows*cols
// load beats (s_tuser = 0) in row-major order, then pull beats (s_tuser = 1).
// Each pull gives one result beat: the element of the current orientation,
// walking original, transpose, anti-transpose, rotate 180, clockwise and
// counter-clockwise, 6*rows*cols results in all. m_tlast marks the final one,
// after which the block loads a fresh matrix. Pulls while loading and loads
// while reading are dropped without a result.
// Throughput: one beat per cycle, loads and pulls alike, while s_tready is high;
// each touches one store word and steps the counters in the sequencer.
// Result path: an accepted pull loads the store read register and the tag stage,
// then the output register takes both over and shows the result on m_tvalid.
// Reset: counters clear, rows and cols become 32, the phase is loading; the
// store is not cleared, since every entry is written before it is read.
// Stall: while m_tready is low the output beat holds; one more result waits
// in the read stage, and s_tready drops only when both are full.

module matrix_orientation_reader
    import mor_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_WIDTH-1:0] s_tdata,  // [31:0] value
    input  logic                  s_tuser,  // [0] operation
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_WIDTH-1:0] m_tdata,  // [31:0] element
    output logic [4:0]            m_tuser,  // [2:0] orientation, [3] row_end,
                                            // [4] orientation_end
    output logic                  m_tlast,  // last
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  cols_reg;
    logic              cfg_wr;
    logic              in_fire;
    logic              stall;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_WIDTH-1:0] rdata;
    meta_t             seq_meta;
    meta_t             out_meta;

    // Register port: always ready, register picked by address bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(32);
            cols_reg <= CFG_W'(32);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_ROWS)
                rows_reg <= pwdata[CFG_W-1:0];
            else
                cols_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_COLS) ? {{(32-CFG_W){1'b0}}, cols_reg}
                                           : {{(32-CFG_W){1'b0}}, rows_reg};

    // Accept a beat unless the result path is full
    assign s_tready = !stall;
    assign in_fire  = s_tvalid && s_tready;

    mor_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (in_fire),
        .op       (s_tuser),
        .restart  (cfg_wr),
        .rows     (rows_reg),
        .cols     (cols_reg),
        .mem_we   (mem_we),
        .mem_re   (mem_re),
        .mem_addr (mem_addr),
        .meta     (seq_meta)
    );

    mor_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (s_tdata),
        .rdata (rdata)
    );

    mor_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (mem_re),
        .meta_in   (seq_meta),
        .rdata     (rdata),
        .stall     (stall),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_meta  (out_meta)
    );

    assign m_tuser = {out_meta.orientation_end, out_meta.row_end, out_meta.orientation};
    assign m_tlast = out_meta.last;

endmodule

// ===== hw/rtl/mor_checker.sv =====
// Port-level checks for the matrix orientation reader, bound to the top level.
// Depends on mor_pkg and matrix_orientation_reader.

module mor_checker
    import mor_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [DATA_WIDTH-1:0] m_tdata,
    input logic [4:0]            m_tuser,
    input logic                  m_tlast
);

    // Last beat ends its row and its orientation, and only in the final one
    a_last_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[3] && m_tuser[4] && m_tuser[2:0] == ORI_CCW)
        else $error("last beat without row and orientation end");

    a_oend_rend: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4] |-> m_tuser[3])
        else $error("orientation end without row end");

    a_ori_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[2:0] <= ORI_CCW)
        else $error("orientation code out of range");

    // Orientation only advances right after an orientation end
    a_ori_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser[4] ##1 m_tvalid |-> m_tuser[2:0] == $past(m_tuser[2:0]))
        else $error("orientation changed inside an orientation");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

endmodule

bind matrix_orientation_reader mor_checker u_mor_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/testbench.sv =====
// Self-checking bench for matrix_orientation_reader: streams load and pull
// beats, predicts each oriented element and flag set, and compares them
// beat by beat. Depends on mor_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
    import mor_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int IDLE_PERCENT = 23;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1100;

    // One beat offered on the input stream
    typedef struct {
        logic                  op;
        logic [DATA_WIDTH-1:0] value;
    } load_pull_t;

    // One oriented element as the block should emit it
    typedef struct {
        logic [DATA_WIDTH-1:0] element;
        logic [ORI_W-1:0]      orientation;
        logic                  row_end;
        logic                  ori_end;
        logic                  seq_last;
    } oriented_elem_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_WIDTH-1:0] s_tdata  = '0;     // [31:0] value
    logic                  s_tuser  = OP_LOAD; // [0] operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_WIDTH-1:0] m_tdata;           // [31:0] element
    logic [4:0]            m_tuser;           // [2:0] orientation, [3] row_end,
                                              // [4] orientation_end
    logic                  m_tlast;           // last
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [2:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    matrix_orientation_reader dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // Beats waiting to be offered, and elements waiting to come out
    load_pull_t     beats_to_send[$];
    oriented_elem_t pending_elems[$];

    // Shadow of the block: stored matrix, counters and dimension registers
    logic [DATA_WIDTH-1:0] matrix_img [DEPTH];
    logic [CFG_W-1:0]      rows_cfg = 6'd32;
    logic [CFG_W-1:0]      cols_cfg = 6'd32;
    int                    loaded_n;
    bit                    reading;
    logic [ORI_W-1:0]      cur_ori;
    int                    cur_outer;
    int                    cur_inner;

    // Bench bookkeeping
    bit steady      = 1'b0;  // suppress idling on both sides
    int stall_asked = 0;     // bump to ask the receiver for a long hold
    int stall_taken = 0;
    int hold_left   = 0;
    int cycle_count = 0;
    int beats_sent  = 0;
    int elems_checked = 0;
    int mismatch_count = 0;
    int random_items = 0;
    int settings_used = 0;

    // A dimension of 0 acts as 1, anything above the maximum acts as the maximum
    function automatic int eff_dim(input logic [CFG_W-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void restart_walk();
        loaded_n  = 0;
        reading   = 1'b0;
        cur_ori   = ORI_ORIGINAL;
        cur_outer = 0;
        cur_inner = 0;
    endfunction

    // Advance the shadow by one accepted beat; return 1 when it yields an element
    function automatic bit orient_step(input logic op, input logic [DATA_WIDTH-1:0] val,
                                       output oriented_elem_t res);
        int h;
        int w;
        int outer_n;
        int inner_n;
        int i;
        int j;
        int r;
        int c;
        h = eff_dim(rows_cfg, MAX_ROWS);
        w = eff_dim(cols_cfg, MAX_COLS);
        res = '{default: '0};
        if (!reading) begin
            if (op == OP_LOAD) begin
                matrix_img[(loaded_n / w) * MAX_COLS + (loaded_n % w)] = val;
                loaded_n++;
                if (loaded_n >= h * w) begin
                    restart_walk();
                    reading = 1'b1;
                end
            end
            return 1'b0;
        end
        // Loads are dropped while the matrix is being read out
        if (op == OP_LOAD)
            return 1'b0;

        outer_n = (cur_ori == ORI_ORIGINAL || cur_ori == ORI_ROT180) ? h : w;
        inner_n = (cur_ori == ORI_ORIGINAL || cur_ori == ORI_ROT180) ? w : h;
        i = (cur_outer >= outer_n) ? outer_n - 1 : cur_outer;
        j = (cur_inner >= inner_n) ? inner_n - 1 : cur_inner;
        case (cur_ori)
            ORI_ORIGINAL:       begin r = i;         c = j;         end
            ORI_TRANSPOSE:      begin r = j;         c = i;         end
            ORI_ANTI_TRANSPOSE: begin r = h - 1 - j; c = w - 1 - i; end
            ORI_ROT180:         begin r = h - 1 - i; c = w - 1 - j; end
            ORI_CW:             begin r = h - 1 - j; c = i;         end
            default:            begin r = j;         c = w - 1 - i; end
        endcase
        res.element     = matrix_img[r * MAX_COLS + c];
        res.orientation = cur_ori;
        res.row_end     = (j + 1 == inner_n);
        res.ori_end     = res.row_end && (i + 1 == outer_n);
        res.seq_last    = res.ori_end && (cur_ori >= ORI_CCW);

        if (res.seq_last) begin
            restart_walk();
        end
        else if (res.ori_end) begin
            cur_ori   = cur_ori + 1'b1;
            cur_outer = 0;
            cur_inner = 0;
        end
        else if (res.row_end) begin
            cur_outer = i + 1;
            cur_inner = 0;
        end
        else begin
            cur_inner = j + 1;
        end
        return 1'b1;
    endfunction

    // Mix corner values into otherwise random words
    function automatic logic [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_beat(input logic op, input logic [DATA_WIDTH-1:0] val);
        load_pull_t b;
        b.op    = op;
        b.value = val;
        beats_to_send.push_back(b);
    endtask

    // Queue one load-then-read sequence, with stray beats of the wrong kind
    // sprinkled in; optionally cut it short so the next register write lands
    // in the middle of a sequence.
    task automatic push_sequence(input int h, input int w, input bit cut_short);
        int total;
        int stop_at;
        total   = 7 * h * w;
        stop_at = cut_short ? $urandom_range(1, total - 1) : total;
        for (int k = 0; k < stop_at; k++) begin
            if ($urandom_range(0, 11) == 0)
                push_beat((k < h * w) ? OP_PULL : OP_LOAD, rand_word());
            push_beat((k < h * w) ? OP_LOAD : OP_PULL, rand_word());
            random_items++;
        end
    endtask

    // Wait until every beat is taken and every element has come back, then
    // let the two-stage read path settle.
    task automatic drain();
        @(negedge clk);
        while (beats_to_send.size() != 0 || s_tvalid || pending_elems.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Register write: setup cycle, then access cycle; update the shadow once
    // the write edge has passed.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {26'($urandom_range(0, (1 << 26) - 1)), v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROWS)
            rows_cfg = v;
        else
            cols_cfg = v;
        restart_walk();
        settings_used++;
    endtask

    // Sender: hold a beat until taken, then offer the next one or idle
    always @(posedge clk) begin : feed
        oriented_elem_t res;
        load_pull_t     nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                beats_sent++;
                if (orient_step(s_tuser, s_tdata, res))
                    pending_elems.push_back(res);
            end
            if (!s_tvalid || s_tready) begin
                if (beats_to_send.size() != 0 &&
                    (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    nxt = beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= nxt.value;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold when one is asked for
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_asked != stall_taken) begin
            stall_taken <= stall_asked;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else begin
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Checker: match each accepted output beat against the oldest prediction
    always @(posedge clk) begin : check
        oriented_elem_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_elems.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0d] unexpected beat: elem %h ori %0d flags %b%b%b",
                             cycle_count, m_tdata, m_tuser[2:0], m_tuser[3], m_tuser[4],
                             m_tlast);
            end
            else begin
                want = pending_elems.pop_front();
                elems_checked++;
                if (m_tdata !== want.element || m_tuser[2:0] !== want.orientation ||
                    m_tuser[3] !== want.row_end || m_tuser[4] !== want.ori_end ||
                    m_tlast !== want.seq_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("[%0d] beat %0d: expected elem %h ori %0d flags %b%b%b",
                                 cycle_count, elems_checked, want.element, want.orientation,
                                 want.row_end, want.ori_end, want.seq_last);
                        $display("    got elem %h ori %0d flags %b%b%b",
                                 m_tdata, m_tuser[2:0], m_tuser[3], m_tuser[4], m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d elements still due",
                     cycle_count, pending_elems.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int n_seq;
        for (int a = 0; a < DEPTH; a++)
            matrix_img[a] = '0;
        restart_walk();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: 1x2 matrix with extreme words; a pull before loading and a
        // load during read-out are both dropped.
        write_reg(REG_ROWS, 6'd1);
        write_reg(REG_COLS, 6'd2);
        @(negedge clk);
        push_beat(OP_PULL, 32'hffff_ffff);
        push_beat(OP_LOAD, 32'h8000_0000);
        push_beat(OP_LOAD, 32'h7fff_ffff);
        push_beat(OP_LOAD, 32'h0000_0000);
        for (int k = 0; k < 12; k++)
            push_beat(OP_PULL, 32'h0000_0000);
        drain();

        // Directed: rows of zero acts as one; single element ends every row,
        // every orientation, and finally the sequence; the pull after it is
        // dropped since the block is loading again.
        write_reg(REG_ROWS, 6'd0);
        write_reg(REG_COLS, 6'd1);
        @(negedge clk);
        push_beat(OP_LOAD, 32'hffff_ffff);
        for (int k = 0; k < 7; k++)
            push_beat(OP_PULL, 32'h5555_aaaa);
        drain();

        // Back-pressure: load a 3x3, then hold the receiver off while pulls
        // pile up and the block stalls its input.
        write_reg(REG_ROWS, 6'd3);
        write_reg(REG_COLS, 6'd3);
        @(negedge clk);
        for (int k = 0; k < 9; k++)
            push_beat(OP_LOAD, rand_word());
        drain();
        stall_asked++;
        for (int k = 0; k < 54; k++)
            push_beat(OP_PULL, rand_word());
        drain();

        // Oversized values clamp: 63 rows by 0 cols reads as a 32x1 column
        write_reg(REG_ROWS, 6'd63);
        write_reg(REG_COLS, 6'd0);
        @(negedge clk);
        push_sequence(eff_dim(rows_cfg, MAX_ROWS), eff_dim(cols_cfg, MAX_COLS), 1'b0);
        drain();

        // Wide run, 40 cols clamping to a 2x32 matrix, with no idling on either side
        write_reg(REG_ROWS, 6'd2);
        write_reg(REG_COLS, 6'd40);
        @(negedge clk);
        steady = 1'b1;
        push_sequence(eff_dim(rows_cfg, MAX_ROWS), eff_dim(cols_cfg, MAX_COLS), 1'b0);
        drain();
        steady = 1'b0;

        // Random phases on small matrices; some end mid-sequence so the next
        // write restarts the block.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       write_reg(REG_ROWS, CFG_W'($urandom_range(0, 5)));
                1:       write_reg(REG_COLS, CFG_W'($urandom_range(0, 5)));
                default: begin
                    write_reg(REG_ROWS, CFG_W'($urandom_range(0, 6)));
                    write_reg(REG_COLS, CFG_W'($urandom_range(0, 6)));
                end
            endcase
            @(negedge clk);
            n_seq = $urandom_range(1, 3);
            for (int s = 0; s < n_seq; s++)
                push_sequence(eff_dim(rows_cfg, MAX_ROWS), eff_dim(cols_cfg, MAX_COLS),
                              (s == n_seq - 1) && ($urandom_range(0, 4) == 0));
            drain();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d input beats and %0d checked elements over %0d register writes",
                 beats_sent, elems_checked, settings_used);
        $display("mismatches %0d, elements left unmatched %0d",
                 mismatch_count, pending_elems.size());
        if (mismatch_count == 0 && pending_elems.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
